FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define GR_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define GR_ASSERT_NORST(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define GR_ASSERT(lbl, clk, rst, prop, msg)

`define GR_ASSERT_NORST(lbl, clk, prop, msg)

`endif

`endif

FILE: rtl/gtrp_pkg.sv
// ----------------------------------------------------------------------------
// Rainbow pseudocolor package
// Types, register indexes and helper functions for the grey to rainbow map.
// ----------------------------------------------------------------------------
`default_nettype none

package gtrp_pkg;

   localparam int PIXEL_BITS = 8;
   localparam int KNEE_BITS  = 9;
   localparam int NUMER_BITS = 2 * PIXEL_BITS;
   localparam int SHIFT_BITS = 3;
   localparam int INDEX_BITS = 3;
   localparam int KNEE_COUNT = 6;
   localparam int CHAN_COUNT = 3;
   localparam int LUT_DEPTH  = 1 << PIXEL_BITS;

   localparam int CHAN_RED   = 0;
   localparam int CHAN_GREEN = 1;
   localparam int CHAN_BLUE  = 2;

   localparam logic [PIXEL_BITS-1:0] LEVEL_FULL = '1;
   localparam logic [SHIFT_BITS-1:0] MAX_SHIFT  = 3'd6;

   localparam logic [INDEX_BITS-1:0] REG_KNEE_VIOLET     = 3'd0;
   localparam logic [INDEX_BITS-1:0] REG_KNEE_BLUE       = 3'd1;
   localparam logic [INDEX_BITS-1:0] REG_KNEE_LIGHT_BLUE = 3'd2;
   localparam logic [INDEX_BITS-1:0] REG_KNEE_GREEN      = 3'd3;
   localparam logic [INDEX_BITS-1:0] REG_KNEE_YELLOW     = 3'd4;
   localparam logic [INDEX_BITS-1:0] REG_KNEE_RED        = 3'd5;
   localparam logic [INDEX_BITS-1:0] REG_REDUCTION_SHIFT = 3'd6;

   localparam logic [KNEE_BITS-1:0] KNEE_RESET [KNEE_COUNT] =
      '{9'd0, 9'd51, 9'd102, 9'd153, 9'd204, 9'd255};

   typedef enum logic [1:0] {
      RAMP_ZERO,
      RAMP_FULL,
      RAMP_UP,
      RAMP_DOWN
   } ramp_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_SETUP,
      SEQ_LOAD,
      SEQ_DIV
   } seq_state_type;

   typedef struct packed {
      ramp_type             kind;
      logic [KNEE_BITS-1:0] lo;
      logic [KNEE_BITS-1:0] hi;
   } seg_type;

   typedef struct packed {
      logic [NUMER_BITS-1:0] numer;
      logic [KNEE_BITS-1:0]  denom;
   } div_req_type;

   function automatic logic [KNEE_BITS-1:0] knee_max(input logic [KNEE_BITS-1:0] a,
                                                      input logic [KNEE_BITS-1:0] b);
      return (a > b) ? a : b;
   endfunction

   // d*255 for a rising ramp, d*255 + span - 1 for a falling one (ceiling)
   function automatic logic [NUMER_BITS-1:0] seg_numer(input logic [PIXEL_BITS-1:0] x,
                                                        input seg_type s);
      logic [PIXEL_BITS-1:0] d;
      logic [KNEE_BITS-1:0]  span;
      logic [NUMER_BITS:0]   n;
      d    = x - s.lo[PIXEL_BITS-1:0];
      span = s.hi - s.lo;
      n    = {1'b0, d, {PIXEL_BITS{1'b0}}} - {{(PIXEL_BITS+1){1'b0}}, d};
      if (s.kind == RAMP_DOWN) begin
         n = n + {{(NUMER_BITS+1-KNEE_BITS){1'b0}}, span} - 17'd1;
      end
      return n[NUMER_BITS-1:0];
   endfunction

   function automatic logic [PIXEL_BITS-1:0] chan_level(input ramp_type kind,
                                                         input logic [PIXEL_BITS-1:0] q);
      logic [PIXEL_BITS-1:0] lvl;
      case (kind)
         RAMP_ZERO: lvl = '0;
         RAMP_FULL: lvl = LEVEL_FULL;
         RAMP_UP:   lvl = q;
         RAMP_DOWN: lvl = LEVEL_FULL - q;
         default:   lvl = '0;
      endcase
      return lvl;
   endfunction

   function automatic logic [PIXEL_BITS-1:0] level_mask(input logic [SHIFT_BITS-1:0] sh);
      logic [PIXEL_BITS-1:0] m;
      m = LEVEL_FULL;
      if (sh <= MAX_SHIFT) begin
         m = LEVEL_FULL << sh;
      end
      return m;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/gtrp_div.sv
// ----------------------------------------------------------------------------
// Ramp divider
// Restoring divider, one quotient bit per cycle; quotient is known to fit
// in one pixel word.
// ----------------------------------------------------------------------------
`default_nettype none

module gtrp_div (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             load,
   input  wire gtrp_pkg::div_req_type            req,
   output logic [gtrp_pkg::PIXEL_BITS-1:0]       quot,
   output logic                                  done
);

   localparam int CNT_BITS = $clog2(gtrp_pkg::PIXEL_BITS + 1);
   localparam logic [CNT_BITS-1:0] DIV_STEPS = CNT_BITS'(gtrp_pkg::PIXEL_BITS);

   logic [CNT_BITS-1:0]               cnt_ff;
   logic [gtrp_pkg::KNEE_BITS-1:0]    rem_ff;
   logic [gtrp_pkg::PIXEL_BITS-1:0]   low_ff;
   logic [gtrp_pkg::PIXEL_BITS-1:0]   quot_ff;
   logic [gtrp_pkg::KNEE_BITS-1:0]    denom_ff;
   logic [gtrp_pkg::KNEE_BITS:0]      rem_sh;
   logic [gtrp_pkg::KNEE_BITS:0]      rem_diff;
   logic                              fit;

   always_comb begin
      rem_sh   = {rem_ff, low_ff[gtrp_pkg::PIXEL_BITS-1]};
      fit      = rem_sh >= {1'b0, denom_ff};
      rem_diff = rem_sh - {1'b0, denom_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= DIV_STEPS;
      end else if (load) begin
         cnt_ff <= '0;
      end else if (cnt_ff != DIV_STEPS) begin
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rem_ff   <= {1'b0, req.numer[gtrp_pkg::NUMER_BITS-1:gtrp_pkg::PIXEL_BITS]};
         low_ff   <= req.numer[gtrp_pkg::PIXEL_BITS-1:0];
         quot_ff  <= '0;
         denom_ff <= req.denom;
      end else if (cnt_ff != DIV_STEPS) begin
         rem_ff  <= fit ? rem_diff[gtrp_pkg::KNEE_BITS-1:0] : rem_sh[gtrp_pkg::KNEE_BITS-1:0];
         low_ff  <= {low_ff[gtrp_pkg::PIXEL_BITS-2:0], 1'b0};
         quot_ff <= {quot_ff[gtrp_pkg::PIXEL_BITS-2:0], fit};
      end
   end

   assign quot = quot_ff;
   assign done = (cnt_ff == DIV_STEPS);

endmodule

`default_nettype wire

FILE: rtl/grey_to_rainbow_pseudocolour.sv
// ----------------------------------------------------------------------------
// Grey to rainbow pseudocolor
// Maps an 8-bit grey level to an RGB triple through a 256-entry color table
// that is rebuilt from the knee registers by three ramp dividers, one per channel.
//
//   Channel   Ports                                   Handshake
//   request   req_grey_level                          start, busy
//   response  rsp_red_level/green_level/blue_level    rsp_valid strobe
//   csr       csr_index, csr_data                     csr_we
//
// One pixel per cycle while busy is low; the response is registered in the table read and output registers.
// The table memory read port sets the rate: one read per cycle while not busy.
// After reset and after each knee write the table is rebuilt with busy high (one
// setup step, then a load and a divide step per entry); a knee write restarts it.
// The quantization shift applies on the read path and needs no rebuild.
// The receiver cannot stall: each response is valid for one cycle only.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module grey_to_rainbow_pseudocolour (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic [gtrp_pkg::PIXEL_BITS-1:0]     req_grey_level,
   output logic                                     rsp_valid,
   output logic [gtrp_pkg::PIXEL_BITS-1:0]          rsp_red_level,
   output logic [gtrp_pkg::PIXEL_BITS-1:0]          rsp_green_level,
   output logic [gtrp_pkg::PIXEL_BITS-1:0]          rsp_blue_level,
   input  wire logic                                csr_we,
   input  wire logic [gtrp_pkg::INDEX_BITS-1:0]     csr_index,
   input  wire logic [gtrp_pkg::KNEE_BITS-1:0]      csr_data
);

   localparam int PB = gtrp_pkg::PIXEL_BITS;
   localparam int KB = gtrp_pkg::KNEE_BITS;
   localparam int KC = gtrp_pkg::KNEE_COUNT;
   localparam int CC = gtrp_pkg::CHAN_COUNT;

   logic [KB-1:0]                       knee_ff [KC];
   logic [KB-1:0]                       ord_in [KC];
   logic [KB-1:0]                       ord_ff [KC];
   logic [gtrp_pkg::SHIFT_BITS-1:0]     shift_ff;
   logic                                knee_wr;

   gtrp_pkg::seq_state_type             state_ff;
   gtrp_pkg::seq_state_type             state_in;
   logic [PB-1:0]                       x_ff;
   logic [PB-1:0]                       x_in;
   logic                                div_load;
   logic                                lut_we;

   gtrp_pkg::seg_type                   seg [CC];
   gtrp_pkg::div_req_type               div_req [CC];
   gtrp_pkg::ramp_type                  kind_ff [CC];
   logic [PB-1:0]                       quot [CC];
   logic [CC-1:0]                       div_done;

   logic [CC*PB-1:0]                    lut_mem [gtrp_pkg::LUT_DEPTH];
   logic [CC*PB-1:0]                    lut_wdata;
   logic [CC*PB-1:0]                    rd_data_ff;
   logic                                rd_en;
   logic                                rd_valid_ff;
   logic                                rsp_valid_ff;
   logic [PB-1:0]                       mask;
   logic [PB-1:0]                       red_ff;
   logic [PB-1:0]                       green_ff;
   logic [PB-1:0]                       blue_ff;

   // ------------------------------------------------------------------ csr
   assign knee_wr = csr_we && (csr_index <= gtrp_pkg::REG_KNEE_RED);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < KC; i++) begin
            knee_ff[i] <= gtrp_pkg::KNEE_RESET[i];
         end
         shift_ff <= '0;
      end else if (csr_we) begin
         if (knee_wr) begin
            knee_ff[csr_index] <= csr_data;
         end else if (csr_index == gtrp_pkg::REG_REDUCTION_SHIFT) begin
            shift_ff <= csr_data[gtrp_pkg::SHIFT_BITS-1:0];
         end
      end
   end

   // raise each knee to at least the one before it
   always_comb begin
      ord_in[0] = knee_ff[0];
      for (int i = 1; i < KC; i++) begin
         ord_in[i] = gtrp_pkg::knee_max(knee_ff[i], ord_in[i-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == gtrp_pkg::SEQ_SETUP) begin
         ord_ff <= ord_in;
      end
   end

   // ------------------------------------------------------------ segments
   always_comb begin
      logic [KB-1:0] xe;
      logic [KB-1:0] kv;
      logic [KB-1:0] kb;
      logic [KB-1:0] kl;
      logic [KB-1:0] kg;
      logic [KB-1:0] ky;
      logic [KB-1:0] kr;
      xe = {1'b0, x_ff};
      kv = ord_ff[gtrp_pkg::REG_KNEE_VIOLET];
      kb = ord_ff[gtrp_pkg::REG_KNEE_BLUE];
      kl = ord_ff[gtrp_pkg::REG_KNEE_LIGHT_BLUE];
      kg = ord_ff[gtrp_pkg::REG_KNEE_GREEN];
      ky = ord_ff[gtrp_pkg::REG_KNEE_YELLOW];
      kr = ord_ff[gtrp_pkg::REG_KNEE_RED];

      if (xe < kv) begin
         seg[gtrp_pkg::CHAN_RED] = '{gtrp_pkg::RAMP_FULL, kv, kb};
      end else if (xe < kb) begin
         seg[gtrp_pkg::CHAN_RED] = '{gtrp_pkg::RAMP_DOWN, kv, kb};
      end else if (xe < kg) begin
         seg[gtrp_pkg::CHAN_RED] = '{gtrp_pkg::RAMP_ZERO, kg, ky};
      end else if (xe < ky) begin
         seg[gtrp_pkg::CHAN_RED] = '{gtrp_pkg::RAMP_UP, kg, ky};
      end else begin
         seg[gtrp_pkg::CHAN_RED] = '{gtrp_pkg::RAMP_FULL, kg, ky};
      end

      if (xe < kb) begin
         seg[gtrp_pkg::CHAN_GREEN] = '{gtrp_pkg::RAMP_ZERO, kb, kl};
      end else if (xe < kl) begin
         seg[gtrp_pkg::CHAN_GREEN] = '{gtrp_pkg::RAMP_UP, kb, kl};
      end else if (xe < ky) begin
         seg[gtrp_pkg::CHAN_GREEN] = '{gtrp_pkg::RAMP_FULL, ky, kr};
      end else if (xe < kr) begin
         seg[gtrp_pkg::CHAN_GREEN] = '{gtrp_pkg::RAMP_DOWN, ky, kr};
      end else begin
         seg[gtrp_pkg::CHAN_GREEN] = '{gtrp_pkg::RAMP_ZERO, ky, kr};
      end

      if (xe < kl) begin
         seg[gtrp_pkg::CHAN_BLUE] = '{gtrp_pkg::RAMP_FULL, kl, kg};
      end else if (xe < kg) begin
         seg[gtrp_pkg::CHAN_BLUE] = '{gtrp_pkg::RAMP_DOWN, kl, kg};
      end else begin
         seg[gtrp_pkg::CHAN_BLUE] = '{gtrp_pkg::RAMP_ZERO, kl, kg};
      end
   end

   always_comb begin
      for (int c = 0; c < CC; c++) begin
         div_req[c].numer = gtrp_pkg::seg_numer(x_ff, seg[c]);
         div_req[c].denom = seg[c].hi - seg[c].lo;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == gtrp_pkg::SEQ_LOAD) begin
         kind_ff <= '{seg[0].kind, seg[1].kind, seg[2].kind};
      end
   end

   for (genvar c = 0; c < CC; c++) begin : g_div
      gtrp_div u_div (
         .clock (clock),
         .reset (reset),
         .load  (div_load),
         .req   (div_req[c]),
         .quot  (quot[c]),
         .done  (div_done[c])
      );
   end

   assign lut_wdata = {gtrp_pkg::chan_level(kind_ff[gtrp_pkg::CHAN_RED],
                                            quot[gtrp_pkg::CHAN_RED]),
                       gtrp_pkg::chan_level(kind_ff[gtrp_pkg::CHAN_GREEN],
                                            quot[gtrp_pkg::CHAN_GREEN]),
                       gtrp_pkg::chan_level(kind_ff[gtrp_pkg::CHAN_BLUE],
                                            quot[gtrp_pkg::CHAN_BLUE])};

   // ------------------------------------------------------------ sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gtrp_pkg::SEQ_SETUP;
         x_ff     <= '0;
      end else begin
         state_ff <= state_in;
         x_ff     <= x_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      div_load = 1'b0;
      lut_we   = 1'b0;
      case (state_ff)
         gtrp_pkg::SEQ_IDLE: begin
            state_in = gtrp_pkg::SEQ_IDLE;
         end
         gtrp_pkg::SEQ_SETUP: begin
            x_in     = '0;
            state_in = gtrp_pkg::SEQ_LOAD;
         end
         gtrp_pkg::SEQ_LOAD: begin
            div_load = 1'b1;
            state_in = gtrp_pkg::SEQ_DIV;
         end
         gtrp_pkg::SEQ_DIV: begin
            if (&div_done) begin
               lut_we = 1'b1;
               if (x_ff == gtrp_pkg::LEVEL_FULL) begin
                  state_in = gtrp_pkg::SEQ_IDLE;
               end else begin
                  x_in     = x_ff + 1'b1;
                  state_in = gtrp_pkg::SEQ_LOAD;
               end
            end
         end
         default: begin
            state_in = gtrp_pkg::SEQ_IDLE;
         end
      endcase
      // restart the rebuild on any knee write
      if (knee_wr) begin
         state_in = gtrp_pkg::SEQ_SETUP;
      end
   end

   assign busy = (state_ff != gtrp_pkg::SEQ_IDLE);

   // -------------------------------------------------------------- table
   assign rd_en = start && !busy;

   always_ff @(posedge clock) begin
      if (lut_we) begin
         lut_mem[x_ff] <= lut_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= lut_mem[req_grey_level];
      end
   end

   // ------------------------------------------------------------ response
   assign mask = gtrp_pkg::level_mask(shift_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff  <= rd_en;
         rsp_valid_ff <= rd_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_valid_ff) begin
         red_ff   <= rd_data_ff[3*PB-1:2*PB] & mask;
         green_ff <= rd_data_ff[2*PB-1:PB] & mask;
         blue_ff  <= rd_data_ff[PB-1:0] & mask;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_red_level   = red_ff;
   assign rsp_green_level = green_ff;
   assign rsp_blue_level  = blue_ff;

   // ----------------------------------------------------------- assertions
   `GR_ASSERT(a_rsp_follows_transfer, clock, reset, rsp_valid |-> $past(start && !busy, 2), "response without a request transfer")
   `GR_ASSERT(a_div_lockstep, clock, reset, (div_done[0] == div_done[1]) && (div_done[1] == div_done[2]), "ramp dividers out of step")
   `GR_ASSERT_NORST(a_knee_write_rebuilds, clock, (csr_we && (csr_index <= gtrp_pkg::REG_KNEE_RED)) |=> busy, "knee write did not start a rebuild")

endmodule

`default_nettype wire

FILE: tb/grey_to_rainbow_pseudocolour_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Rainbow pseudocolor map testbench
// Drives grey pixels through the start/busy request port under several knee
// and quantization settings, predicts each RGB response from the register
// copies held here, and checks every response strobe in order.
// ----------------------------------------------------------------------------

module grey_to_rainbow_pseudocolour_test;

   localparam int PB = gtrp_pkg::PIXEL_BITS;
   localparam int KB = gtrp_pkg::KNEE_BITS;
   localparam logic [gtrp_pkg::INDEX_BITS-1:0] REG_UNUSED = 3'd7;
   localparam int unsigned FULL_LEVEL = 255;
   localparam int STALL_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 4;

   typedef struct packed {
      logic [PB-1:0] red;
      logic [PB-1:0] green;
      logic [PB-1:0] blue;
   } pixel_color_type;

   logic                                 clock = 1'b0;
   logic                                 reset;
   logic                                 start;
   logic                                 busy;
   logic [PB-1:0]                        req_grey_level;
   logic                                 rsp_valid;
   logic [PB-1:0]                        rsp_red_level;
   logic [PB-1:0]                        rsp_green_level;
   logic [PB-1:0]                        rsp_blue_level;
   logic                                 csr_we;
   logic [gtrp_pkg::INDEX_BITS-1:0]      csr_index;
   logic [KB-1:0]                        csr_data;

   logic [KB-1:0]                        knee_setting [gtrp_pkg::KNEE_COUNT];
   logic [gtrp_pkg::SHIFT_BITS-1:0]      shift_setting;
   pixel_color_type                      pending_colours [$];
   int                                   error_count = 0;
   int                                   stall_cycles = 0;
   bit                                   idle_enable = 1'b1;

   grey_to_rainbow_pseudocolour i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_grey_level  (req_grey_level),
      .rsp_valid       (rsp_valid),
      .rsp_red_level   (rsp_red_level),
      .rsp_green_level (rsp_green_level),
      .rsp_blue_level  (rsp_blue_level),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int unsigned ramp_rise(input int unsigned x, input int unsigned lo,
                                              input int unsigned hi);
      int unsigned span;
      span = hi - lo;
      if (span == 0) return 0;
      return ((x - lo) * FULL_LEVEL) / span;
   endfunction

   function automatic int unsigned ramp_fall(input int unsigned x, input int unsigned lo,
                                              input int unsigned hi);
      int unsigned span;
      int unsigned q;
      span = hi - lo;
      if (span == 0) return FULL_LEVEL;
      q = ((x - lo) * FULL_LEVEL + span - 1) / span;
      return (q >= FULL_LEVEL) ? 0 : FULL_LEVEL - q;
   endfunction

   function automatic pixel_color_type rainbow_colour(input logic [PB-1:0] grey);
      int unsigned x, v, b, lb, g, y, r;
      int unsigned red, green, blue, mask;
      int unsigned k1, k2, k3, k4, k5;
      pixel_color_type c;
      x  = grey;
      k1 = knee_setting[gtrp_pkg::REG_KNEE_BLUE];
      k2 = knee_setting[gtrp_pkg::REG_KNEE_LIGHT_BLUE];
      k3 = knee_setting[gtrp_pkg::REG_KNEE_GREEN];
      k4 = knee_setting[gtrp_pkg::REG_KNEE_YELLOW];
      k5 = knee_setting[gtrp_pkg::REG_KNEE_RED];
      v  = knee_setting[gtrp_pkg::REG_KNEE_VIOLET];
      b  = (k1 > v) ? k1 : v;
      lb = (k2 > b) ? k2 : b;
      g  = (k3 > lb) ? k3 : lb;
      y  = (k4 > g) ? k4 : g;
      r  = (k5 > y) ? k5 : y;

      if (x < v)       red = FULL_LEVEL;
      else if (x < b)  red = ramp_fall(x, v, b);
      else if (x < g)  red = 0;
      else if (x < y)  red = ramp_rise(x, g, y);
      else             red = FULL_LEVEL;

      if (x < b)       green = 0;
      else if (x < lb) green = ramp_rise(x, b, lb);
      else if (x < y)  green = FULL_LEVEL;
      else if (x < r)  green = ramp_fall(x, y, r);
      else             green = 0;

      if (x < lb)      blue = FULL_LEVEL;
      else if (x < g)  blue = ramp_fall(x, lb, g);
      else             blue = 0;

      mask = FULL_LEVEL;
      if (shift_setting <= gtrp_pkg::MAX_SHIFT) begin
         mask = (FULL_LEVEL >> shift_setting) << shift_setting;
      end
      c.red   = PB'(red & mask);
      c.green = PB'(green & mask);
      c.blue  = PB'(blue & mask);
      return c;
   endfunction

   task automatic write_reg(input logic [gtrp_pkg::INDEX_BITS-1:0] idx,
                            input logic [KB-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == gtrp_pkg::REG_REDUCTION_SHIFT) begin
         shift_setting = data[gtrp_pkg::SHIFT_BITS-1:0];
      end else if (idx < gtrp_pkg::KNEE_COUNT) begin
         knee_setting[idx] = data;
      end
      @(posedge clock);
   endtask

   task automatic write_knees(input int unsigned k0, input int unsigned k1,
                              input int unsigned k2, input int unsigned k3,
                              input int unsigned k4, input int unsigned k5);
      write_reg(gtrp_pkg::REG_KNEE_VIOLET, KB'(k0));
      write_reg(gtrp_pkg::REG_KNEE_BLUE, KB'(k1));
      write_reg(gtrp_pkg::REG_KNEE_LIGHT_BLUE, KB'(k2));
      write_reg(gtrp_pkg::REG_KNEE_GREEN, KB'(k3));
      write_reg(gtrp_pkg::REG_KNEE_YELLOW, KB'(k4));
      write_reg(gtrp_pkg::REG_KNEE_RED, KB'(k5));
   endtask

   // hold start until busy is low at an edge, then queue the prediction
   task automatic send_pixel(input logic [PB-1:0] grey);
      if (idle_enable && $urandom_range(0, 4) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      start          <= 1'b1;
      req_grey_level <= grey;
      do @(posedge clock); while (busy !== 1'b0);
      pending_colours.push_back(rainbow_colour(grey));
   endtask

   task automatic drain_colours;
      start <= 1'b0;
      while (pending_colours.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic void check_level(input string channel, input logic [PB-1:0] exp_level,
                                       input logic [PB-1:0] act_level);
      if (act_level !== exp_level) begin
         $display("%0t: %s level mismatch, expected %0d, actual %0d",
                  $time, channel, exp_level, act_level);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      pixel_color_type exp_colour;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_colours.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual r=%0d g=%0d b=%0d",
                     $time, rsp_red_level, rsp_green_level, rsp_blue_level);
            error_count++;
         end else begin
            exp_colour = pending_colours.pop_front();
            check_level("red", exp_colour.red, rsp_red_level);
            check_level("green", exp_colour.green, rsp_green_level);
            check_level("blue", exp_colour.blue, rsp_blue_level);
         end
      end
   end

   always @(posedge clock) begin
      if ((start === 1'b1 && busy === 1'b0) || rsp_valid === 1'b1) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
         $display("Verification failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic test_default_knees;
      write_reg(gtrp_pkg::REG_REDUCTION_SHIFT, '0);
      foreach (knee_setting[i]) send_pixel(PB'(gtrp_pkg::KNEE_RESET[i]));
      send_pixel(8'd1);
      send_pixel(8'd25);
      send_pixel(8'd76);
      send_pixel(8'd127);
      send_pixel(8'd229);
      send_pixel(8'd254);
      drain_colours();
   endtask

   // knees out of order, one above the grey range and one at the 9-bit top
   task automatic test_unordered_knees;
      write_knees(200, 100, 50, 300, 10, 511);
      send_pixel(8'd0);
      send_pixel(8'd150);
      send_pixel(8'd199);
      send_pixel(8'd200);
      send_pixel(8'd255);
      drain_colours();
   endtask

   task automatic test_equal_knees;
      write_knees(128, 128, 128, 128, 128, 128);
      send_pixel(8'd127);
      send_pixel(8'd128);
      drain_colours();
      write_knees(256, 256, 256, 256, 256, 256);
      send_pixel(8'd255);
      drain_colours();
   endtask

   task automatic test_reduction_shift;
      write_knees(0, 51, 102, 153, 204, 255);
      write_reg(gtrp_pkg::REG_REDUCTION_SHIFT, KB'(gtrp_pkg::MAX_SHIFT));
      send_pixel(8'd30);
      send_pixel(8'd180);
      drain_colours();
      write_reg(gtrp_pkg::REG_REDUCTION_SHIFT, KB'(7));
      send_pixel(8'd30);
      send_pixel(8'd180);
      drain_colours();
   endtask

   task automatic test_unused_index;
      write_reg(REG_UNUSED, 9'h1FF);
      send_pixel(8'd60);
      drain_colours();
      write_reg(gtrp_pkg::REG_REDUCTION_SHIFT, '0);
      send_pixel(8'd60);
      drain_colours();
   endtask

   function automatic int unsigned corner_knee;
      case ($urandom_range(0, 4))
         0:       return 0;
         1:       return 255;
         2:       return 256;
         3:       return 511;
         default: return $urandom_range(0, 255);
      endcase
   endfunction

   task automatic test_random_colours;
      int unsigned k [gtrp_pkg::KNEE_COUNT];
      int unsigned grey;
      int sel;
      for (int phase = 0; phase < 16; phase++) begin
         idle_enable = (phase < 13);
         case ($urandom_range(0, 3))
            0: begin
               k[0] = $urandom_range(0, 80);
               for (int i = 1; i < gtrp_pkg::KNEE_COUNT; i++) begin
                  k[i] = k[i-1] + $urandom_range(0, 70);
               end
            end
            1: foreach (k[i]) k[i] = $urandom_range(0, 511);
            2: foreach (k[i]) k[i] = corner_knee();
            default: begin
               k[0] = $urandom_range(0, 255);
               for (int i = 1; i < gtrp_pkg::KNEE_COUNT; i++) begin
                  k[i] = k[i-1] + $urandom_range(0, 3);
               end
            end
         endcase
         write_knees(k[0], k[1], k[2], k[3], k[4], k[5]);
         write_reg(gtrp_pkg::REG_REDUCTION_SHIFT, KB'($urandom_range(0, 7)));
         repeat (60) begin
            if ($urandom_range(0, 3) == 0) begin
               sel  = $urandom_range(0, gtrp_pkg::KNEE_COUNT - 1);
               grey = knee_setting[sel] + $urandom_range(0, 2);
               grey = (grey == 0) ? 0 : grey - 1;
               if (grey > FULL_LEVEL) grey = $urandom_range(0, 255);
            end else begin
               grey = $urandom_range(0, 255);
            end
            send_pixel(PB'(grey));
         end
         drain_colours();
      end
   endtask

   initial begin
      reset          <= 1'b1;
      start          <= 1'b0;
      req_grey_level <= '0;
      csr_we         <= 1'b0;
      csr_index      <= '0;
      csr_data       <= '0;
      foreach (knee_setting[i]) knee_setting[i] = gtrp_pkg::KNEE_RESET[i];
      shift_setting = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_default_knees();
      test_unordered_knees();
      test_equal_knees();
      test_reduction_shift();
      test_unused_index();
      test_random_colours();

      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
